// ===== design/pn_pkg.sv =====
package pn_pkg;

    localparam int MAX_NAME  = 63;
    localparam int BUF_DEPTH = MAX_NAME + 1;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int WI_W      = $clog2(BUF_DEPTH + 1);
    localparam int SEP_W     = 6;
    localparam int LEN_W     = 7;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [WI_W-1:0] ROOT_LEN = WI_W'(2);

    // controller -> datapath
    typedef struct packed {
        logic put_in;     // put the incoming byte
        logic put_dot;    // put a held-back dot
        logic put_cur;    // put the captured byte
        logic cap;
        logic go_root;
        logic set_start;
        logic clr_start;
        logic pend_inc;
        logic pend_dec;
        logic pend_clr;
        logic set_err;
        logic bk_start;
        logic bk_read;
        logic bk_step;
        logic fin_slash;
        logic out_init;
        logic out_read;
        logic out_load;
        logic out_err;
        logic out_next;
        logic clear_all;
    } pn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       in_zero;
        logic       in_slash;
        logic       in_dot;
        logic       at_start;
        logic [1:0] pend;
        logic       err;
        logic       wi_gt2;
        logic       last_slash;
        logic       rd_slash;
        logic       out_last;
    } pn_sts_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ===== design/pn_ram.sv =====
module pn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/pn_ctrl.sv =====
module pn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  pn_pkg::pn_sts_t  sts,
    output pn_pkg::pn_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_PUT,
        ST_BK_RD,
        ST_BK_CHK,
        ST_TERM,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   term_reg, term_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT_WAIT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.in_zero)
                    begin
                        term_next  = 1'b1;
                        state_next = ST_TERM;
                        if (!sts.err && sts.pend != 2'd0)
                        begin
                            cmd.pend_clr  = 1'b1;
                            cmd.set_start = 1'b1;
                            if (sts.pend == 2'd2)
                            begin
                                if (sts.wi_gt2)
                                begin
                                    cmd.bk_start = 1'b1;
                                    state_next   = ST_BK_RD;
                                end
                                else
                                begin
                                    cmd.set_err = 1'b1;
                                end
                            end
                        end
                    end
                    else if (sts.err)
                    begin
                        // bytes after an error are dropped
                    end
                    else if (sts.in_slash)
                    begin
                        if (sts.at_start)
                        begin
                            cmd.go_root = 1'b1;
                        end
                        else if (sts.pend != 2'd0)
                        begin
                            cmd.pend_clr  = 1'b1;
                            cmd.set_start = 1'b1;
                            if (sts.pend == 2'd2)
                            begin
                                if (sts.wi_gt2)
                                begin
                                    cmd.bk_start = 1'b1;
                                    state_next   = ST_BK_RD;
                                end
                                else
                                begin
                                    cmd.set_err = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            cmd.put_in    = 1'b1;
                            cmd.set_start = 1'b1;
                        end
                    end
                    else if (sts.in_dot && (sts.at_start || sts.pend != 2'd0))
                    begin
                        cmd.clr_start = 1'b1;
                        if (sts.pend != 2'd2)
                        begin
                            cmd.pend_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.cap    = 1'b1;
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        cmd.clr_start = 1'b1;
                        if (sts.pend == 2'd0)
                        begin
                            cmd.put_in = 1'b1;
                        end
                        else
                        begin
                            cmd.cap    = 1'b1;
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.put_dot  = 1'b1;
                cmd.pend_dec = 1'b1;
                if (sts.pend == 2'd1)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.put_cur = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_BK_RD:
            begin
                if (sts.wi_gt2)
                begin
                    cmd.bk_read = 1'b1;
                    state_next  = ST_BK_CHK;
                end
                else
                begin
                    state_next = term_reg ? ST_TERM : ST_IDLE;
                end
            end
            ST_BK_CHK:
            begin
                if (sts.rd_slash)
                begin
                    state_next = term_reg ? ST_TERM : ST_IDLE;
                end
                else
                begin
                    cmd.bk_step = 1'b1;
                    state_next  = ST_BK_RD;
                end
            end
            ST_TERM:
            begin
                if (sts.err)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_OUT_WAIT;
                end
                else
                begin
                    cmd.fin_slash = !sts.last_slash;
                    cmd.out_init  = 1'b1;
                    state_next    = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                cmd.out_read = 1'b1;
                state_next   = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    if (sts.out_last)
                    begin
                        cmd.clear_all = 1'b1;
                        term_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

endmodule

// ===== design/pn_dp.sv =====
module pn_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    path_byte,
    input  pn_pkg::pn_cmd_t               cmd,
    output pn_pkg::pn_sts_t               sts,
    output logic [7:0]                    out_byte,
    output logic                          last_of_run,
    output logic                          status,
    output logic [pn_pkg::LEN_W-1:0]      path_length,
    output logic [pn_pkg::SEP_W-1:0]      level_count
);

    logic [pn_pkg::WI_W-1:0]   wi_reg, wi_next;
    logic [pn_pkg::SEP_W-1:0]  sep_reg, sep_next;
    logic                      last_slash_reg, last_slash_next;
    logic                      err_reg, err_next;
    logic                      start_reg, start_next;
    logic [1:0]                pend_reg, pend_next;
    logic [pn_pkg::BUF_AW-1:0] k_reg, k_next;
    logic [7:0]                cur_reg;

    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;
    logic                      status_reg;
    logic [pn_pkg::LEN_W-1:0]  len_reg;
    logic [pn_pkg::SEP_W-1:0]  lvl_reg;

    logic [7:0]                put_data, put_up, wdata, rdata;
    logic                      put_en, put_ok, put_ovf, put_is_slash;
    logic                      we, re;
    logic [pn_pkg::BUF_AW-1:0] waddr, raddr;
    logic [pn_pkg::WI_W-1:0]   wi_m1, k_p1;

    assign put_en   = cmd.put_in | cmd.put_dot | cmd.put_cur;
    assign put_data = cmd.put_in  ? path_byte :
                      cmd.put_dot ? pn_pkg::CH_DOT : cur_reg;
    assign put_up   = pn_pkg::to_upper(put_data);
    assign put_is_slash = (put_data == pn_pkg::CH_SLASH);
    assign put_ok  = put_en & !err_reg & (wi_reg < pn_pkg::WI_W'(pn_pkg::MAX_NAME));
    assign put_ovf = put_en & !err_reg & !(wi_reg < pn_pkg::WI_W'(pn_pkg::MAX_NAME));

    assign wi_m1 = wi_reg - pn_pkg::WI_W'(1);
    assign k_p1  = {1'b0, k_reg} + pn_pkg::WI_W'(1);

    assign we    = put_ok | cmd.fin_slash;
    assign waddr = wi_reg[pn_pkg::BUF_AW-1:0];
    assign wdata = cmd.fin_slash ? pn_pkg::CH_SLASH : put_up;
    assign re    = cmd.bk_read | cmd.out_read;
    assign raddr = cmd.bk_read ? wi_m1[pn_pkg::BUF_AW-1:0] : k_reg;

    pn_ram #(
        .WIDTH(8),
        .DEPTH(pn_pkg::BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        wi_next         = wi_reg;
        sep_next        = sep_reg;
        last_slash_next = last_slash_reg;
        if (cmd.clear_all || cmd.go_root)
        begin
            wi_next         = pn_pkg::ROOT_LEN;
            sep_next        = '0;
            last_slash_next = 1'b1;
        end
        else if (put_ok)
        begin
            wi_next         = wi_reg + pn_pkg::WI_W'(1);
            sep_next        = sep_reg + pn_pkg::SEP_W'(put_is_slash);
            last_slash_next = put_is_slash;
        end
        else if (cmd.bk_start)
        begin
            // drop the trailing separator; the walk stops after the one before
            wi_next         = wi_m1;
            sep_next        = sep_reg - pn_pkg::SEP_W'(1);
            last_slash_next = 1'b1;
        end
        else if (cmd.bk_step)
        begin
            wi_next = wi_m1;
        end
        else if (cmd.fin_slash)
        begin
            wi_next         = wi_reg + pn_pkg::WI_W'(1);
            sep_next        = sep_reg + pn_pkg::SEP_W'(1);
            last_slash_next = 1'b1;
        end

        err_next = err_reg;
        if (cmd.clear_all)
        begin
            err_next = 1'b0;
        end
        else if (cmd.set_err || put_ovf)
        begin
            err_next = 1'b1;
        end

        start_next = start_reg;
        if (cmd.clear_all || cmd.set_start)
        begin
            start_next = 1'b1;
        end
        else if (cmd.clr_start)
        begin
            start_next = 1'b0;
        end

        pend_next = pend_reg;
        if (cmd.clear_all || cmd.pend_clr)
        begin
            pend_next = 2'd0;
        end
        else if (cmd.pend_inc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (cmd.pend_dec)
        begin
            pend_next = pend_reg - 2'd1;
        end

        k_next = k_reg;
        if (cmd.out_init)
        begin
            k_next = '0;
        end
        else if (cmd.out_next)
        begin
            k_next = k_reg + pn_pkg::BUF_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg         <= pn_pkg::ROOT_LEN;
            sep_reg        <= '0;
            last_slash_reg <= 1'b1;
            err_reg        <= 1'b0;
            start_reg      <= 1'b1;
            pend_reg       <= 2'd0;
            k_reg          <= '0;
        end
        else
        begin
            wi_reg         <= wi_next;
            sep_reg        <= sep_next;
            last_slash_reg <= last_slash_next;
            err_reg        <= err_next;
            start_reg      <= start_next;
            pend_reg       <= pend_next;
            k_reg          <= k_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cur_reg <= path_byte;
        end
        if (cmd.out_err)
        begin
            out_byte_reg <= pn_pkg::CH_NUL;
            out_last_reg <= 1'b1;
            status_reg   <= 1'b1;
            len_reg      <= '0;
            lvl_reg      <= '0;
        end
        else if (cmd.out_load)
        begin
            // root prefix is never read back from the buffer
            if (k_reg == '0)
            begin
                out_byte_reg <= pn_pkg::CH_SLASH;
            end
            else if (k_reg == pn_pkg::BUF_AW'(1) || rdata == pn_pkg::CH_SLASH)
            begin
                out_byte_reg <= pn_pkg::CH_NUL;
            end
            else
            begin
                out_byte_reg <= rdata;
            end
            out_last_reg <= (k_p1 == wi_reg);
            status_reg   <= 1'b0;
            len_reg      <= pn_pkg::LEN_W'(wi_reg);
            lvl_reg      <= sep_reg + pn_pkg::SEP_W'(1);
        end
    end

    assign sts.in_zero    = (path_byte == pn_pkg::CH_NUL);
    assign sts.in_slash   = (path_byte == pn_pkg::CH_SLASH);
    assign sts.in_dot     = (path_byte == pn_pkg::CH_DOT);
    assign sts.at_start   = start_reg;
    assign sts.pend       = pend_reg;
    assign sts.err        = err_reg;
    assign sts.wi_gt2     = (wi_reg > pn_pkg::ROOT_LEN);
    assign sts.last_slash = last_slash_reg;
    assign sts.rd_slash   = (rdata == pn_pkg::CH_SLASH);
    assign sts.out_last   = out_last_reg;

    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign status      = status_reg;
    assign path_length = len_reg;
    assign level_count = lvl_reg;

endmodule

// ===== design/path_normalizer.sv =====
// Path normalizer: takes a path one byte per input transfer, ended by a zero
// byte, and returns its canonical form one byte per output transfer.
// Input channel: path_byte with in_valid/in_ready. Output channel: out_byte,
// last_of_run, status, path_length, level_count with out_valid/out_ready.
// Non-zero bytes produce no output. On the zero byte the block sends either
// one error transfer (status 1) or the normalized bytes, later separators as
// zero bytes after a leading '/', with last_of_run on the final one.
// An ordinary byte or slash is handled in the idle state. A byte after held
// dots is captured, then each dot and the byte get one buffer write each. A
// '..' walks back, reading and comparing each byte removed, until it hits
// the previous separator or the walk reaches the root. After the zero byte
// (and any '..' walk it ends), a buffer read and an output load precede
// out_valid, which an error result raises without them; each output byte
// takes a buffer read, an output load and its transfer, plus any receiver
// stall. The single buffer write port and registered read port shape these steps.
// Input is taken only while no path is being emitted; a stalled receiver
// holds the current output steady and blocks new input.
// Reset returns to an empty root path; the buffer itself is not cleared and
// needs no clearing pass.
module path_normalizer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               path_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_byte,
    output logic                     last_of_run,
    output logic                     status,
    output logic [pn_pkg::LEN_W-1:0] path_length,
    output logic [pn_pkg::SEP_W-1:0] level_count
);

    pn_pkg::pn_cmd_t cmd;
    pn_pkg::pn_sts_t sts;

    pn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pn_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .path_byte   (path_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .status      (status),
        .path_length (path_length),
        .level_count (level_count)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while output pending");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> path_length == '0 && level_count == '0 && last_of_run)
        else $error("error result malformed");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> path_length >= pn_pkg::LEN_W'(2))
        else $error("normalized path shorter than root");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_run |=> in_ready)
        else $error("not idle after last transfer");

endmodule

// ===== tb/sv/path_normalizer_tb.sv =====
`timescale 1ns / 100ps

module path_normalizer_tb;

    localparam int RANDOM_BYTES   = 90;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0]               out_data;
        logic                     is_last;
        logic                     bad;
        logic [pn_pkg::LEN_W-1:0] len;
        logic [pn_pkg::SEP_W-1:0] levels;
    } norm_res_t;

    typedef enum int {COMP_NAME, COMP_DOT, COMP_DOTDOT, COMP_EMPTY, COMP_HELD_DOTS} comp_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_PULSE, RX_STARVE} rx_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [7:0]               path_byte;
    logic                     out_valid;
    logic                     out_ready;
    logic [7:0]               out_byte;
    logic                     last_of_run;
    logic                     status;
    logic [pn_pkg::LEN_W-1:0] path_length;
    logic [pn_pkg::SEP_W-1:0] level_count;

    path_normalizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .path_byte   (path_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .status      (status),
        .path_length (path_length),
        .level_count (level_count)
    );

    // canonical path state kept alongside the block
    logic [7:0] canon_buf [0:pn_pkg::BUF_DEPTH-1];
    int         canon_len;
    bit         canon_at_start;
    int         canon_dots;
    bit         canon_err;

    norm_res_t  expected_q [$];
    logic [7:0] path_q [$];

    int bytes_sent;
    int paths_sent;
    int out_checked;
    int err_runs;
    int fail_count;
    int burst_left;
    int quiet_cycles;
    int rx_tick;
    rx_mode_t rx_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void canon_clear();
        canon_buf[0]   = pn_pkg::CH_SLASH;
        canon_buf[1]   = pn_pkg::CH_SLASH;
        canon_len      = 2;
        canon_at_start = 1'b1;
        canon_dots     = 0;
        canon_err      = 1'b0;
    endfunction

    function automatic void canon_put(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (canon_err)
        begin
            return;
        end
        if (canon_len >= pn_pkg::MAX_NAME)
        begin
            canon_err = 1'b1;
            return;
        end
        if (c >= pn_pkg::CH_LOW_A && c <= pn_pkg::CH_LOW_Z)
        begin
            u = c & 8'hDF;
        end
        canon_buf[canon_len] = u;
        canon_len++;
    endfunction

    function automatic void canon_back_up();
        if (canon_len <= 2)
        begin
            canon_err = 1'b1;
            return;
        end
        canon_len--;
        while (canon_len > 2 && canon_buf[canon_len-1] != pn_pkg::CH_SLASH)
        begin
            canon_len--;
        end
    endfunction

    function automatic void canon_end_dots();
        if (canon_dots == 2)
        begin
            canon_back_up();
        end
        canon_dots     = 0;
        canon_at_start = 1'b1;
    endfunction

    // advance the canonical path by one byte; the zero byte queues the output run
    function automatic void canon_step(input logic [7:0] c);
        int        k;
        int        seps;
        norm_res_t r;
        if (c != pn_pkg::CH_NUL)
        begin
            if (canon_err)
            begin
                return;
            end
            if (c == pn_pkg::CH_SLASH)
            begin
                if (canon_at_start)
                begin
                    canon_len = 2;
                end
                else if (canon_dots != 0)
                begin
                    canon_end_dots();
                end
                else
                begin
                    canon_put(pn_pkg::CH_SLASH);
                    canon_at_start = 1'b1;
                end
            end
            else if (c == pn_pkg::CH_DOT && (canon_at_start || canon_dots != 0))
            begin
                canon_at_start = 1'b0;
                if (canon_dots < 2)
                begin
                    canon_dots++;
                end
                else
                begin
                    // third dot: the held pair becomes part of a name
                    canon_put(pn_pkg::CH_DOT);
                    canon_put(pn_pkg::CH_DOT);
                    canon_put(pn_pkg::CH_DOT);
                    canon_dots = 0;
                end
            end
            else
            begin
                canon_at_start = 1'b0;
                for (k = 0; k < canon_dots; k++)
                begin
                    canon_put(pn_pkg::CH_DOT);
                end
                canon_dots = 0;
                canon_put(c);
            end
            return;
        end

        if (!canon_err && canon_dots != 0)
        begin
            canon_end_dots();
        end
        if (canon_err)
        begin
            r.out_data = pn_pkg::CH_NUL;
            r.is_last  = 1'b1;
            r.bad      = 1'b1;
            r.len      = '0;
            r.levels   = '0;
            expected_q.push_back(r);
            err_runs++;
            canon_clear();
            return;
        end
        if (canon_len < pn_pkg::BUF_DEPTH && canon_buf[canon_len-1] != pn_pkg::CH_SLASH)
        begin
            canon_buf[canon_len] = pn_pkg::CH_SLASH;
            canon_len++;
        end
        seps = 0;
        for (k = 1; k < canon_len; k++)
        begin
            if (canon_buf[k] == pn_pkg::CH_SLASH)
            begin
                seps++;
            end
        end
        for (k = 0; k < canon_len; k++)
        begin
            r.out_data = (k >= 1 && canon_buf[k] == pn_pkg::CH_SLASH) ? pn_pkg::CH_NUL
                                                                       : canon_buf[k];
            r.is_last  = (k == canon_len - 1);
            r.bad      = 1'b0;
            r.len      = pn_pkg::LEN_W'(canon_len);
            r.levels   = pn_pkg::SEP_W'(seps);
            expected_q.push_back(r);
        end
        canon_clear();
    endfunction

    task automatic send_path_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        path_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        canon_step(b);
        bytes_sent++;
    endtask

    task automatic run_path();
        foreach (path_q[i])
        begin
            send_path_byte(path_q[i]);
        end
        send_path_byte(pn_pkg::CH_NUL);
        path_q.delete();
        paths_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            path_q.push_back(s[i]);
        end
    endfunction

    function automatic void add_rep(input logic [7:0] b, input int n);
        for (int i = 0; i < n; i++)
        begin
            path_q.push_back(b);
        end
    endfunction

    function automatic void add_name(input int n);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                b = pn_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
            end
            else if (r < 8)
            begin
                b = ($urandom_range(0, 1) != 0) ? 8'h41 + 8'($urandom_range(0, 25))
                                                : 8'h30 + 8'($urandom_range(0, 9));
            end
            else
            begin
                // any non-zero byte except the separator
                b = 8'($urandom_range(1, 254));
                if (b >= pn_pkg::CH_SLASH)
                begin
                    b = b + 8'd1;
                end
            end
            path_q.push_back(b);
        end
    endfunction

    function automatic void build_wellformed_path();
        int         n_comp;
        int         r;
        comp_kind_t kind;
        if ($urandom_range(0, 3) == 0)
        begin
            path_q.push_back(pn_pkg::CH_SLASH);
        end
        n_comp = $urandom_range(0, 6);
        for (int i = 0; i < n_comp; i++)
        begin
            if (i != 0)
            begin
                path_q.push_back(pn_pkg::CH_SLASH);
            end
            r = $urandom_range(0, 99);
            if (r < 55)      kind = COMP_NAME;
            else if (r < 67) kind = COMP_DOT;
            else if (r < 80) kind = COMP_DOTDOT;
            else if (r < 86) kind = COMP_EMPTY;
            else             kind = COMP_HELD_DOTS;
            case (kind)
                COMP_NAME:
                begin
                    if ($urandom_range(0, 19) == 0)
                        add_name($urandom_range(30, 62));
                    else
                        add_name($urandom_range(1, 8));
                end
                COMP_DOT:       add_str(".");
                COMP_DOTDOT:    add_str("..");
                COMP_EMPTY:     ;
                COMP_HELD_DOTS:
                begin
                    add_rep(pn_pkg::CH_DOT, $urandom_range(1, 3));
                    add_name($urandom_range(0, 3));
                end
                default:        ;
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            path_q.push_back(pn_pkg::CH_SLASH);
        end
    endfunction

    function automatic void build_noise_path();
        int n;
        int r;
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)      path_q.push_back(pn_pkg::CH_SLASH);
            else if (r < 6) path_q.push_back(pn_pkg::CH_DOT);
            else            path_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    task automatic test_empty_path();
        run_path();
        add_str("/");
        run_path();
    endtask

    task automatic test_plain_components();
        add_str("abc");
        run_path();
        add_str("/usr/bin/");
        run_path();
    endtask

    task automatic test_dot_components();
        add_str("./a/./b/.");
        run_path();
        add_str("a/b/..");
        run_path();
        add_str("..");
        run_path();
        add_str("a/../..");
        run_path();
        // error mid-path: the rest is ignored
        add_str("q/../../zz/a");
        run_path();
    endtask

    task automatic test_held_dots();
        add_str(".x/..y/...");
        run_path();
        add_str("a/....b./c..");
        run_path();
    endtask

    task automatic test_slash_resets();
        add_str("a//b");
        run_path();
        add_str("ab/c//");
        run_path();
    endtask

    task automatic test_byte_extremes();
        path_q.push_back(8'h01);
        path_q.push_back(8'h60);
        path_q.push_back(pn_pkg::CH_LOW_A);
        path_q.push_back(pn_pkg::CH_LOW_Z);
        path_q.push_back(8'h7B);
        path_q.push_back(8'h7F);
        path_q.push_back(8'h80);
        path_q.push_back(8'hFF);
        path_q.push_back(8'h40);
        path_q.push_back(8'h5B);
        run_path();
    endtask

    task automatic test_overflow();
        // many levels filling every regular entry: final slash lands in the spare entry
        for (int i = 0; i < (pn_pkg::MAX_NAME - 3) / 2; i++)
        begin
            add_str("d/");
        end
        add_str("d");
        run_path();
        // name byte one past the limit
        add_rep(8'h7A, pn_pkg::MAX_NAME - 1);
        run_path();
        // separator one past the limit
        add_rep(8'h62, pn_pkg::MAX_NAME - 2);
        add_str("/");
        run_path();
    endtask

    task automatic test_random_paths();
        int  start_bytes;
        bit  paused;
        start_bytes = bytes_sent;
        paused      = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if (!paused && bytes_sent - start_bytes >= RANDOM_BYTES / 2)
            begin
                pause_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
                build_wellformed_path();
            else
                build_noise_path();
            run_path();
        end
    endtask

    // receiver: out_ready follows a stall pattern that is redrawn at random
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 50 == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_PULSE:  out_ready <= (rx_tick % 7) < 3;
            RX_STARVE: out_ready <= (rx_tick % 16) == 0;
            default:   out_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : check_out
        norm_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %0h", out_byte);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                out_checked++;
                if (out_byte !== want.out_data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_data, out_byte);
                    fail_count++;
                end
                if (last_of_run !== want.is_last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.is_last, last_of_run);
                    fail_count++;
                end
                if (status !== want.bad)
                begin
                    $error("status: expected %0d, got %0d", want.bad, status);
                    fail_count++;
                end
                if (path_length !== want.len)
                begin
                    $error("path_length: expected %0d, got %0d", want.len, path_length);
                    fail_count++;
                end
                if (level_count !== want.levels)
                begin
                    $error("level_count: expected %0d, got %0d", want.levels, level_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        path_byte    = 8'h00;
        out_ready    = 1'b0;
        bytes_sent   = 0;
        paths_sent   = 0;
        out_checked  = 0;
        err_runs     = 0;
        fail_count   = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        rx_tick      = 0;
        rx_mode      = RX_OPEN;
        canon_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_path();
        test_plain_components();
        test_dot_components();
        test_held_dots();
        test_slash_resets();
        test_byte_extremes();
        test_overflow();
        test_random_paths();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d paths, %0d path bytes in, %0d output transfers checked",
                 paths_sent, bytes_sent, out_checked);
        $display("summary: %0d paths ended in error, %0d mismatches", err_runs, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
